// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/p2bf_pkg.sv -----
package p2bf_pkg;

  localparam int OP_W   = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 11;

  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd4;

endpackage

// ----- design/pow2_byte_ring_fifo.sv -----
// Channel   Direction  Handshake                    Payload
// command   in         start_i high, busy_o low     op_i, data_in_i, count_i
// result    out        result_strobe_o, one cycle   data_out_o, data_valid_o, last_o,
//                                                   amount_o, level_o
//
// Write, discard, unused codes and empty fill/read/peek: result the next cycle;
// a new command may follow at once. Fill of n bytes: busy while the n bytes are
// written, one store write per cycle. Read/peek of n bytes: busy while the n bytes
// are read, one store read per cycle; results follow the registered read data, back to back.
// Reset clears both pointers (FIFO empty); store contents are not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
`include "assert_macros.svh"

module pow2_byte_ring_fifo #(
  parameter int DEPTH_LOG2     = 10,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [p2bf_pkg::OP_W-1:0]     op_i,
  input  logic [p2bf_pkg::DATA_W-1:0]   data_in_i,
  input  logic [p2bf_pkg::CNT_W-1:0]    count_i,
  output logic                          result_strobe_o,
  output logic [p2bf_pkg::DATA_W-1:0]   data_out_o,
  output logic                          data_valid_o,
  output logic                          last_o,
  output logic [p2bf_pkg::CNT_W-1:0]    amount_o,
  output logic [p2bf_pkg::CNT_W-1:0]    level_o
);

  localparam int AW    = DEPTH_LOG2;
  localparam int PW    = DEPTH_LOG2 + 1;
  localparam int CW    = (PW > p2bf_pkg::CNT_W) ? PW : p2bf_pkg::CNT_W;
  localparam int DEPTH = 2 ** DEPTH_LOG2;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [p2bf_pkg::DATA_W-1:0] mem [DEPTH];
  logic [p2bf_pkg::DATA_W-1:0] rdata_q;

  logic [1:0]                  state_q;
  logic [PW-1:0]               wptr_q, rptr_q, raddr_q, rem_q;
  logic [PW-1:0]               amt_q, lvl_res_q;
  logic [p2bf_pkg::DATA_W-1:0] fill_q;
  logic                        res_vld_q, res_dv_q, res_last_q;

  logic [PW-1:0] lvl, space, n_fill, n_rd, n_dis;
  logic [CW-1:0] count_ext, lvl_ext, space_ext, max_ext, capped;
  logic [CW-1:0] n_fill_w, n_rd_w, n_dis_w, amt_ext, lvl_out_ext;
  logic          full, accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [p2bf_pkg::DATA_W-1:0] mem_wdata;

  assign lvl       = wptr_q - rptr_q;
  assign space     = DEPTH_P - lvl;
  assign full      = (lvl == DEPTH_P);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);

  assign count_ext = CW'(count_i);
  assign lvl_ext   = CW'(lvl);
  assign space_ext = CW'(space);
  assign max_ext   = CW'(MAX_READ_BURST);
  assign capped    = (count_ext > max_ext) ? max_ext : count_ext;
  assign n_fill_w  = (count_ext > space_ext) ? space_ext : count_ext;
  assign n_rd_w    = (capped > lvl_ext) ? lvl_ext : capped;
  assign n_dis_w   = (count_ext > lvl_ext) ? lvl_ext : count_ext;
  assign n_fill    = n_fill_w[PW-1:0];
  assign n_rd      = n_rd_w[PW-1:0];
  assign n_dis     = n_dis_w[PW-1:0];

  // Store writes only happen in idle (single byte) or fill; reads only in the
  // read burst, so a read and a write never touch the store in the same cycle.
  assign mem_we    = (accept && (op_i == p2bf_pkg::OP_WRITE) && !full) ||
                     (state_q == ST_FILL);
  assign mem_waddr = wptr_q[AW-1:0];
  assign mem_wdata = (state_q == ST_FILL) ? fill_q : data_in_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rdata_q <= mem[raddr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wptr_q     <= '0;
      rptr_q     <= '0;
      raddr_q    <= '0;
      rem_q      <= '0;
      amt_q      <= '0;
      lvl_res_q  <= '0;
      fill_q     <= '0;
      res_vld_q  <= 1'b0;
      res_dv_q   <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            res_dv_q   <= 1'b0;
            res_last_q <= 1'b1;
            unique case (op_i) inside
              p2bf_pkg::OP_WRITE: begin
                res_vld_q <= 1'b1;
                if (full) begin
                  amt_q     <= '0;
                  lvl_res_q <= lvl;
                end else begin
                  wptr_q    <= wptr_q + PW'(1);
                  amt_q     <= PW'(1);
                  lvl_res_q <= lvl + PW'(1);
                end
              end
              p2bf_pkg::OP_FILL: begin
                amt_q     <= n_fill;
                lvl_res_q <= lvl + n_fill;
                if (n_fill == '0) begin
                  res_vld_q <= 1'b1;
                end else begin
                  res_vld_q <= 1'b0;
                  state_q   <= ST_FILL;
                  rem_q     <= n_fill;
                  fill_q    <= data_in_i;
                end
              end
              p2bf_pkg::OP_READ, p2bf_pkg::OP_PEEK: begin
                amt_q <= n_rd;
                if (n_rd == '0) begin
                  res_vld_q <= 1'b1;
                  lvl_res_q <= lvl;
                end else begin
                  res_vld_q <= 1'b0;
                  state_q   <= ST_READ;
                  raddr_q   <= rptr_q;
                  rem_q     <= n_rd;
                  if (op_i == p2bf_pkg::OP_READ) begin
                    rptr_q    <= rptr_q + n_rd;
                    lvl_res_q <= lvl - n_rd;
                  end else begin
                    lvl_res_q <= lvl;
                  end
                end
              end
              p2bf_pkg::OP_DISCARD: begin
                res_vld_q <= 1'b1;
                rptr_q    <= rptr_q + n_dis;
                amt_q     <= n_dis;
                lvl_res_q <= lvl - n_dis;
              end
              default: begin
                res_vld_q <= 1'b1;
                amt_q     <= '0;
                lvl_res_q <= lvl;
              end
            endcase
          end else begin
            res_vld_q <= 1'b0;
          end
        end
        ST_FILL: begin
          wptr_q <= wptr_q + PW'(1);
          rem_q  <= rem_q - PW'(1);
          if (rem_q == PW'(1)) begin
            state_q    <= ST_IDLE;
            res_vld_q  <= 1'b1;
            res_dv_q   <= 1'b0;
            res_last_q <= 1'b1;
          end else begin
            res_vld_q  <= 1'b0;
          end
        end
        ST_READ: begin
          // result registers line up with the store's registered read data
          raddr_q    <= raddr_q + PW'(1);
          rem_q      <= rem_q - PW'(1);
          res_vld_q  <= 1'b1;
          res_dv_q   <= 1'b1;
          res_last_q <= (rem_q == PW'(1));
          if (rem_q == PW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q   <= ST_IDLE;
          res_vld_q <= 1'b0;
        end
      endcase
    end
  end

  assign amt_ext     = CW'(amt_q);
  assign lvl_out_ext = CW'(lvl_res_q);

  assign result_strobe_o = res_vld_q;
  assign data_valid_o    = res_vld_q && res_dv_q;
  assign data_out_o      = (res_vld_q && res_dv_q) ? rdata_q : '0;
  assign last_o          = res_last_q;
  assign amount_o        = amt_ext[p2bf_pkg::CNT_W-1:0];
  assign level_o         = lvl_out_ext[p2bf_pkg::CNT_W-1:0];

  `ASSERT_CLK(a_level_bound, clk_i, rst_ni, lvl <= DEPTH_P, "FIFO level above depth")
  `ASSERT_NEVER(a_no_write_in_burst, clk_i, rst_ni, (state_q == ST_READ) && mem_we, "store written during read burst")
  `ASSERT_CLK(a_burst_continues, clk_i, rst_ni, (res_vld_q && res_dv_q && !res_last_q) |=> res_vld_q, "read burst broken before last")

endmodule
